/* design/bfvu_pkg.sv */
package bfvu_pkg;

	// register indexes of the configuration port
	localparam logic [2:0] REG_MIN_DISTANCE     = 3'd0;
	localparam logic [2:0] REG_VIEW_RANGE       = 3'd1;
	localparam logic [2:0] REG_AVOID_FACTOR     = 3'd2;
	localparam logic [2:0] REG_MATCHING_FACTOR  = 3'd3;
	localparam logic [2:0] REG_CENTERING_FACTOR = 3'd4;
	localparam logic [2:0] REG_BIAS_VALUE       = 3'd5;

	localparam int CFG_W   = 31;
	localparam int DIST_W  = 31;
	localparam int WGT_W   = 17;
	localparam int SUM_W   = 48;
	localparam int CNT_W   = 11;
	localparam int IN_DW   = 200;
	localparam int OUT_DW  = 112;

	// group codes
	localparam logic [1:0] GRP_NONE = 2'd0;
	localparam logic [1:0] GRP_POS  = 2'd1;
	localparam logic [1:0] GRP_NEG  = 2'd2;

	// datapath operations
	localparam logic [3:0] OP_NONE   = 4'd0;
	localparam logic [3:0] OP_LOAD   = 4'd1;
	localparam logic [3:0] OP_DIFF   = 4'd2;
	localparam logic [3:0] OP_SQ     = 4'd3;
	localparam logic [3:0] OP_ACC    = 4'd4;
	localparam logic [3:0] OP_MUL_AV = 4'd5;
	localparam logic [3:0] OP_ADDX   = 4'd6;
	localparam logic [3:0] OP_DIVV   = 4'd7;
	localparam logic [3:0] OP_DIVP   = 4'd8;
	localparam logic [3:0] OP_MUL_MT = 4'd9;
	localparam logic [3:0] OP_MUL_CT = 4'd10;
	localparam logic [3:0] OP_MUL_BS = 4'd11;
	localparam logic [3:0] OP_BIAS   = 4'd12;
	localparam logic [3:0] OP_STORE  = 4'd13;
	localparam logic [3:0] OP_EMIT   = 4'd14;

	// square operand selects
	localparam logic [2:0] SQ_MIN  = 3'd3;
	localparam logic [2:0] SQ_VIEW = 3'd4;

	typedef struct packed {
		logic [3:0] op;
		logic [2:0] idx;
	} cmd_t;

	typedef struct packed {
		logic focal;
		logic self_rec;
		logic last;
		logic count_nz;
		logic grp_act;
		logic div_done;
		logic out_busy;
	} stat_t;

	function automatic logic signed [47:0] sat48(input logic signed [48:0] v);
		logic signed [47:0] r;
		if (v[48] != v[47])
			r = v[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
		else
			r = v[47:0];
		return r;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [51:0] v);
		logic signed [31:0] r;
		if ((&v[51:31]) || !(|v[51:31]))
			r = v[31:0];
		else
			r = v[51] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
		return r;
	endfunction

endpackage

/* design/bfvu_div.sv */
module bfvu_div
	import bfvu_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic signed [SUM_W-1:0]  dividend,
	input  logic        [CNT_W-1:0]  divisor,
	output logic                     done,
	output logic signed [SUM_W-1:0]  quotient
);

	logic [SUM_W-1:0] dvd_q;
	logic [SUM_W-1:0] quo_q;
	logic [CNT_W:0]   rem_q;
	logic [CNT_W-1:0] dsr_q;
	logic             neg_q;
	logic             busy_q;
	logic [5:0]       cnt_q;
	logic [CNT_W:0]   rem_sh;
	logic             fit;

	assign rem_sh = {rem_q[CNT_W-1:0], dvd_q[SUM_W-1]};
	assign fit    = rem_sh >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'(SUM_W - 1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend[SUM_W-1] ? (SUM_W)'(-dividend) : dividend;
			neg_q <= dividend[SUM_W-1];
			dsr_q <= divisor;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[SUM_W-2:0], 1'b0};
			rem_q <= fit ? rem_sh - {1'b0, dsr_q} : rem_sh;
			quo_q <= {quo_q[SUM_W-2:0], fit};
		end
	end

	assign quotient = neg_q ? (SUM_W)'(-quo_q) : quo_q;

endmodule

/* design/bfvu_datapath.sv */
module bfvu_datapath
	import bfvu_pkg::*;
#(
	parameter int MAX_BOIDS = 1024
)(
	input  logic              clk,
	input  logic              arst_n,
	input  cmd_t              cmd,
	output stat_t             stat,
	input  logic              cfg_we,
	input  logic [2:0]        cfg_index,
	input  logic [CFG_W-1:0]  cfg_data,
	input  logic [IN_DW-1:0]  s_axis_tdata,
	input  logic [1:0]        s_axis_tuser,
	input  logic              s_axis_tlast,
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	output logic [OUT_DW-1:0] m_axis_tdata
);

	localparam int COUNT_LIMIT = (MAX_BOIDS > 2047) ? 2047 : MAX_BOIDS;

	logic [DIST_W-1:0] min_q, view_q;
	logic [WGT_W-1:0]  avf_q, mtf_q, ctf_q, bias_q;

	logic signed [31:0] fpos_q [3];
	logic signed [31:0] fvel_q [3];
	logic [1:0]         fgrp_q;
	logic signed [31:0] p_q [3];
	logic signed [31:0] v_q [3];
	logic               focal_q, self_q, last_q;

	logic signed [SUM_W-1:0] asum_q [3];
	logic signed [SUM_W-1:0] vsum_q [3];
	logic signed [SUM_W-1:0] psum_q [3];
	logic [CNT_W-1:0]        cnt_q;

	logic signed [32:0] d_q [3];
	logic               far_q;
	logic [61:0]        sq_q;
	logic               sq_pend_q;
	logic [2:0]         sq_idx_q;
	logic [63:0]        dist_q;
	logic [61:0]        min2_q, view2_q;

	logic signed [50:0] prod_q;
	logic signed [31:0] x_q;
	logic signed [31:0] res_q [3];
	logic signed [SUM_W-1:0] avgv_q, avgp_q;
	logic               div_sel_q;

	logic signed [31:0]  out_x_q, out_y_q, out_z_q;
	logic [CNT_W-1:0]    out_cnt_q;
	logic                out_valid_q;

	logic [1:0]          ci;
	logic [DIST_W-1:0]   sq_a;
	logic signed [32:0]  dm;
	logic signed [48:0]  mul_a;
	logic signed [17:0]  mul_w;
	logic signed [66:0]  mul_p;
	logic signed [17:0]  keep, pull;
	logic                div_start, div_done;
	logic signed [SUM_W-1:0] div_dvd, div_quo;

	assign ci   = cmd.idx[1:0];
	assign keep = 18'sd65536 - $signed({1'b0, bias_q});
	assign pull = (fgrp_q == GRP_POS) ? $signed({1'b0, bias_q}) : -$signed({1'b0, bias_q});

	// square operand
	always_comb begin
		dm   = '0;
		sq_a = '0;
		case (cmd.idx)
			SQ_MIN:  sq_a = min_q;
			SQ_VIEW: sq_a = view_q;
			default: begin
				dm   = d_q[ci][32] ? -d_q[ci] : d_q[ci];
				sq_a = dm[DIST_W-1:0];
			end
		endcase
	end

	// weight multiplier operands
	always_comb begin
		mul_a = 49'(asum_q[ci]);
		mul_w = 18'($signed({1'b0, avf_q}));
		case (cmd.op)
			OP_MUL_MT: begin
				mul_a = 49'(avgv_q) - 49'(x_q);
				mul_w = 18'($signed({1'b0, mtf_q}));
			end
			OP_MUL_CT: begin
				mul_a = 49'(avgp_q) - 49'(fpos_q[ci]);
				mul_w = 18'($signed({1'b0, ctf_q}));
			end
			OP_MUL_BS: begin
				mul_a = 49'(x_q);
				mul_w = keep;
			end
			default: ;
		endcase
	end
	assign mul_p = mul_a * mul_w;

	assign div_start = (cmd.op == OP_DIVV) || (cmd.op == OP_DIVP);
	assign div_dvd   = (cmd.op == OP_DIVV) ? vsum_q[ci] : psum_q[ci];

	bfvu_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (cnt_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q  <= 31'd65536;
			view_q <= 31'd655360;
			avf_q  <= 17'd3277;
			mtf_q  <= 17'd3277;
			ctf_q  <= 17'd328;
			bias_q <= 17'd66;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MIN_DISTANCE:     min_q  <= cfg_data;
				REG_VIEW_RANGE:       view_q <= cfg_data;
				REG_AVOID_FACTOR:     avf_q  <= cfg_data[WGT_W-1:0];
				REG_MATCHING_FACTOR:  mtf_q  <= cfg_data[WGT_W-1:0];
				REG_CENTERING_FACTOR: ctf_q  <= cfg_data[WGT_W-1:0];
				REG_BIAS_VALUE:       bias_q <= cfg_data[WGT_W-1:0];
				default: ;
			endcase
		end
	end

	// focal state, accumulators and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				fpos_q[i] <= '0;
				fvel_q[i] <= '0;
				asum_q[i] <= '0;
				vsum_q[i] <= '0;
				psum_q[i] <= '0;
			end
			fgrp_q      <= GRP_NONE;
			cnt_q       <= '0;
			sq_pend_q   <= 1'b0;
			out_valid_q <= 1'b0;
			focal_q     <= 1'b0;
			self_q      <= 1'b0;
			last_q      <= 1'b0;
		end else begin
			// a new result replaces one leaving in the same cycle
			if (cmd.op == OP_EMIT)
				out_valid_q <= 1'b1;
			else if (m_axis_tready)
				out_valid_q <= 1'b0;
			sq_pend_q <= (cmd.op == OP_SQ);
			case (cmd.op)
				OP_LOAD: begin
					focal_q <= !s_axis_tuser[0];
					self_q  <= s_axis_tuser[1];
					last_q  <= s_axis_tlast;
					if (!s_axis_tuser[0]) begin
						for (int i = 0; i < 3; i++) begin
							fpos_q[i] <= s_axis_tdata[32*i +: 32];
							fvel_q[i] <= s_axis_tdata[96 + 32*i +: 32];
							asum_q[i] <= '0;
							vsum_q[i] <= '0;
							psum_q[i] <= '0;
						end
						fgrp_q <= s_axis_tdata[193:192];
						cnt_q  <= '0;
					end
				end
				OP_ACC: begin
					if (!far_q) begin
						if (dist_q < {2'b00, min2_q}) begin
							for (int i = 0; i < 3; i++)
								asum_q[i] <= sat48(49'(asum_q[i]) + 49'(d_q[i]));
						end else if (dist_q < {2'b00, view2_q} &&
								cnt_q < CNT_W'(COUNT_LIMIT)) begin
							for (int i = 0; i < 3; i++) begin
								vsum_q[i] <= sat48(49'(vsum_q[i]) + 49'(v_q[i]));
								psum_q[i] <= sat48(49'(psum_q[i]) + 49'(p_q[i]));
							end
							cnt_q <= cnt_q + CNT_W'(1);
						end
					end
				end
				OP_STORE: fvel_q[ci] <= x_q;
				OP_EMIT: begin
					for (int i = 0; i < 3; i++) begin
						asum_q[i] <= '0;
						vsum_q[i] <= '0;
						psum_q[i] <= '0;
					end
					cnt_q <= '0;
				end
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.op == OP_LOAD) begin
			for (int i = 0; i < 3; i++) begin
				p_q[i] <= s_axis_tdata[32*i +: 32];
				v_q[i] <= s_axis_tdata[96 + 32*i +: 32];
			end
		end
		if (cmd.op == OP_DIFF) begin
			logic f;
			f = 1'b0;
			for (int i = 0; i < 3; i++) begin
				d_q[i] <= 33'(fpos_q[i]) - 33'(p_q[i]);
				if ((33'(fpos_q[i]) - 33'(p_q[i])) > 33'sd2147483647 ||
						(33'(fpos_q[i]) - 33'(p_q[i])) < -33'sd2147483647)
					f = 1'b1;
			end
			far_q <= f;
		end
		if (cmd.op == OP_SQ) begin
			sq_q     <= sq_a * sq_a;
			sq_idx_q <= cmd.idx;
		end
		if (sq_pend_q) begin
			case (sq_idx_q)
				3'd0:    dist_q  <= {2'b00, sq_q};
				SQ_MIN:  min2_q  <= sq_q;
				SQ_VIEW: view2_q <= sq_q;
				default: dist_q  <= dist_q + {2'b00, sq_q};
			endcase
		end
		case (cmd.op)
			OP_MUL_AV: begin
				prod_q <= mul_p[66:16];
				x_q    <= fvel_q[ci];
			end
			OP_MUL_MT, OP_MUL_CT, OP_MUL_BS: prod_q <= mul_p[66:16];
			OP_ADDX: x_q <= sat32(52'(x_q) + 52'(prod_q));
			OP_BIAS: x_q <= sat32(52'(prod_q) + 52'(pull));
			OP_STORE: res_q[ci] <= x_q;
			OP_EMIT: begin
				out_x_q   <= res_q[0];
				out_y_q   <= res_q[1];
				out_z_q   <= res_q[2];
				out_cnt_q <= cnt_q;
			end
			default: ;
		endcase
		if (div_start)
			div_sel_q <= (cmd.op == OP_DIVP);
		if (div_done) begin
			if (div_sel_q)
				avgp_q <= div_quo;
			else
				avgv_q <= div_quo;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {5'd0, out_cnt_q, out_z_q, out_y_q, out_x_q};

	assign stat.focal    = focal_q;
	assign stat.self_rec = self_q;
	assign stat.last     = last_q;
	assign stat.count_nz = (cnt_q != '0);
	assign stat.grp_act  = (fgrp_q == GRP_POS) || (fgrp_q == GRP_NEG);
	assign stat.div_done = div_done;
	assign stat.out_busy = out_valid_q && !m_axis_tready;

endmodule

/* design/bfvu_ctrl.sv */
module bfvu_ctrl
	import bfvu_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  s_axis_tvalid,
	output logic  s_axis_tready,
	input  stat_t stat,
	output cmd_t  cmd
);

	localparam logic [4:0] ST_IDLE = 5'd0;
	localparam logic [4:0] ST_DISP = 5'd1;
	localparam logic [4:0] ST_DIFF = 5'd2;
	localparam logic [4:0] ST_SQ   = 5'd3;
	localparam logic [4:0] ST_SQW  = 5'd4;
	localparam logic [4:0] ST_ACC  = 5'd5;
	localparam logic [4:0] ST_FAV  = 5'd6;
	localparam logic [4:0] ST_FAVA = 5'd7;
	localparam logic [4:0] ST_DV   = 5'd8;
	localparam logic [4:0] ST_DVW  = 5'd9;
	localparam logic [4:0] ST_DP   = 5'd10;
	localparam logic [4:0] ST_DPW  = 5'd11;
	localparam logic [4:0] ST_FMT  = 5'd12;
	localparam logic [4:0] ST_FMTA = 5'd13;
	localparam logic [4:0] ST_FCT  = 5'd14;
	localparam logic [4:0] ST_FCTA = 5'd15;
	localparam logic [4:0] ST_FBS  = 5'd16;
	localparam logic [4:0] ST_FBSA = 5'd17;
	localparam logic [4:0] ST_STORE = 5'd18;
	localparam logic [4:0] ST_EMIT = 5'd19;

	logic [4:0] state_q, state_d;
	logic [2:0] idx_q, idx_d;

	assign s_axis_tready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		idx_d   = idx_q;
		cmd.op  = OP_NONE;
		cmd.idx = idx_q;
		case (state_q)
			ST_IDLE: begin
				if (s_axis_tvalid) begin
					cmd.op  = OP_LOAD;
					state_d = ST_DISP;
				end
			end
			ST_DISP: begin
				idx_d = '0;
				if (stat.focal || stat.self_rec)
					state_d = stat.last ? ST_FAV : ST_IDLE;
				else
					state_d = ST_DIFF;
			end
			ST_DIFF: begin
				cmd.op  = OP_DIFF;
				state_d = ST_SQ;
			end
			ST_SQ: begin
				cmd.op = OP_SQ;
				if (idx_q == SQ_VIEW) begin
					idx_d   = '0;
					state_d = ST_SQW;
				end else begin
					idx_d = idx_q + 3'd1;
				end
			end
			ST_SQW: state_d = ST_ACC;
			ST_ACC: begin
				cmd.op  = OP_ACC;
				state_d = stat.last ? ST_FAV : ST_IDLE;
			end
			ST_FAV: begin
				cmd.op  = OP_MUL_AV;
				state_d = ST_FAVA;
			end
			ST_FAVA: begin
				cmd.op = OP_ADDX;
				if (stat.count_nz)
					state_d = ST_DV;
				else
					state_d = stat.grp_act ? ST_FBS : ST_STORE;
			end
			ST_DV: begin
				cmd.op  = OP_DIVV;
				state_d = ST_DVW;
			end
			ST_DVW: if (stat.div_done) state_d = ST_DP;
			ST_DP: begin
				cmd.op  = OP_DIVP;
				state_d = ST_DPW;
			end
			ST_DPW: if (stat.div_done) state_d = ST_FMT;
			ST_FMT: begin
				cmd.op  = OP_MUL_MT;
				state_d = ST_FMTA;
			end
			ST_FMTA: begin
				cmd.op  = OP_ADDX;
				state_d = ST_FCT;
			end
			ST_FCT: begin
				cmd.op  = OP_MUL_CT;
				state_d = ST_FCTA;
			end
			ST_FCTA: begin
				cmd.op  = OP_ADDX;
				state_d = stat.grp_act ? ST_FBS : ST_STORE;
			end
			ST_FBS: begin
				cmd.op  = OP_MUL_BS;
				state_d = ST_FBSA;
			end
			ST_FBSA: begin
				cmd.op  = OP_BIAS;
				state_d = ST_STORE;
			end
			ST_STORE: begin
				cmd.op = OP_STORE;
				if (idx_q == 3'd2) begin
					state_d = ST_EMIT;
				end else begin
					idx_d   = idx_q + 3'd1;
					state_d = ST_FAV;
				end
			end
			ST_EMIT: begin
				if (!stat.out_busy) begin
					cmd.op  = OP_EMIT;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
		end
	end

endmodule

/* design/boid_flocking_velocity_update.sv */
// Boid flocking velocity update. Send one focal transfer (tuser[0] = 0) with
// the boid's position, velocity and group, then its neighbour records
// (tuser[0] = 1, tuser[1] marks the boid itself); tlast on any record closes
// the run and yields one result transfer with the new velocity and the count
// of visible neighbours. A focal or a self record passes through accept and
// dispatch only; a neighbour record goes through accept, dispatch, one
// difference step, five passes through the shared 31x31 squarer (three
// offsets and the two radii), one wait for the last square and the classify
// step. Closing a run works axis by axis; with visible neighbours it runs
// two 48-step shift-subtract divisions for the averages, with an active
// group bias it adds the bias step, and it ends by loading the output
// register. The result register lets the next run stream in while a result
// waits; only the next closing record stalls behind it. Configuration writes
// take effect at once and must come while the block is idle.
module boid_flocking_velocity_update
	import bfvu_pkg::*;
#(
	parameter int MAX_BOIDS = 1024
)(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [2:0]        cfg_index,
	input  logic [CFG_W-1:0]  cfg_data,
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	// pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, group, zero fill
	input  logic [IN_DW-1:0]  s_axis_tdata,
	// req_type, is_self
	input  logic [1:0]        s_axis_tuser,
	input  logic              s_axis_tlast,
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	// new_vel_x, new_vel_y, new_vel_z, neighbour_count, zero fill
	output logic [OUT_DW-1:0] m_axis_tdata
);

	cmd_t  cmd;
	stat_t stat;

	// sequence each record and the closing arithmetic
	bfvu_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.stat          (stat),
		.cmd           (cmd)
	);

	// hold focal state, sums, squarer, weight multiplier and divider
	bfvu_datapath #(
		.MAX_BOIDS (MAX_BOIDS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

endmodule
